// ===== src/harris_corner_response_macros.svh =====
// Assertion helpers for the Harris corner block
`ifndef HARRIS_CORNER_RESPONSE_MACROS_SVH
`define HARRIS_CORNER_RESPONSE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("harris_corner_response: same-cycle check failed");
// next-cycle implication
`define HCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("harris_corner_response: next-cycle check failed");
`else
`define HCR_ASSERT_NOW(label, clk, rst, ante, cons)
`define HCR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/hcr_pkg.sv =====
package hcr_pkg;

  // input item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_K      = 2'd2;

  // configuration reset values
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;
  localparam logic [15:0] K_RESET      = 16'd4719;

  // neighbourhood offset of one tap
  typedef enum logic [1:0] {
    OFF_MINUS,
    OFF_ZERO,
    OFF_PLUS
  } off_t;

  localparam int TAPS = 9;

  // tap order: row-major over the 3x3 neighbourhood
  localparam off_t TAP_ROW [TAPS] = '{OFF_MINUS, OFF_MINUS, OFF_MINUS,
                                      OFF_ZERO,  OFF_ZERO,  OFF_ZERO,
                                      OFF_PLUS,  OFF_PLUS,  OFF_PLUS};
  localparam off_t TAP_COL [TAPS] = '{OFF_MINUS, OFF_ZERO, OFF_PLUS,
                                      OFF_MINUS, OFF_ZERO, OFF_PLUS,
                                      OFF_MINUS, OFF_ZERO, OFF_PLUS};

  // Sobel weights per tap
  localparam logic signed [2:0] GX_COEF [TAPS] = '{-3'sd1, 3'sd0, 3'sd1,
                                                   -3'sd2, 3'sd0, 3'sd2,
                                                   -3'sd1, 3'sd0, 3'sd1};
  localparam logic signed [2:0] GY_COEF [TAPS] = '{-3'sd1, -3'sd2, -3'sd1,
                                                   3'sd0,  3'sd0,  3'sd0,
                                                   3'sd1,  3'sd2,  3'sd1};

endpackage

// ===== src/harris_corner_response.sv =====
// Harris corner response over a raster stream of 8-bit gray pixels. Each pixel item
// is written into an eight-row line memory; once 2*width+2 pixels lie ahead of the
// output position, the response for that position is computed and delivered with its
// column, row and a last-of-frame flag. After the final pixel of a frame, send drain
// items to flush the remaining responses, one per item. A pixel item that releases no
// response leaves the block idle; one that releases a response (and a drain item that
// does) stalls the input until its result enters the output register, as the single
// read port of the line memory delivers the nine taps of each of the four gradients in
// the 2x2 window one per cycle, followed by the accumulate and two multiply stages.
// Writing frame_width or frame_height restarts the frame; harris_k applies at once.
// Configure only while idle. The line memory needs no clearing pass after reset.
`include "harris_corner_response_macros.svh"

module harris_corner_response #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [46:0] response,
  output logic [9:0]         col,
  output logic [9:0]         row,
  output logic               last_of_frame,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = $clog2(2 * MAX_WIDTH + 4);
  localparam int AW = CW + 3;
  localparam int DEPTH = 8 << CW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  state_t state;

  // configuration
  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [15:0] harris_k;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [DW-1:0] lag;

  // stream positions
  logic [HW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic [DW-1:0] diff;

  // line memory
  logic [7:0]    line_mem [DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] wr_addr, rd_addr;

  // capture of the position being computed
  logic [HW-1:0] cap_y;
  logic [CW-1:0] cap_x;
  logic          cap_last;

  // read sequencer and gradient pipeline
  logic [1:0]        gi;
  logic [3:0]        ti;
  logic              rd_v, rd_gl, rd_fin;
  logic [3:0]        rd_t;
  logic signed [11:0] gx, gy;
  logic              grad_rdy, grad_fin, sum_done;
  logic signed [23:0] sxx, sxy, syy;
  logic signed [47:0] m_a, m_b, det;
  logic [47:0]       tr2;
  logic [63:0]       kprod;
  logic [23:0]       tr_u;
  logic signed [11:0] term_x, term_y;
  logic signed [48:0] res;

  // next-position logic
  logic          in_acc, restart_px, emit_px, emit_dr, dr_restart;
  logic [HW-1:0] wr_row, in_row_adv, src_row, out_row_adv;
  logic [CW-1:0] wr_col, in_col_adv, src_col, out_col_adv;
  logic [DW-1:0] diff_p;

  // address generation
  logic [HW-1:0] gr, pr;
  logic [CW-1:0] gc, pc;
  logic [HW-1:0] h_m1, h_m2;
  logic [CW-1:0] w_m1, w_m2;

  // clamp frame size
  always_comb begin
    if (frame_width < 11'd3) w = WW'(3);
    else if (32'(frame_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(frame_width);
    if (frame_height < 11'd3) h = HW'(3);
    else if (32'(frame_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(frame_height);
    lag  = DW'({w, 1'b0}) + DW'(2);
    h_m1 = h - HW'(1);
    h_m2 = h - HW'(2);
    w_m1 = CW'(w - WW'(1));
    w_m2 = CW'(w - WW'(2));
  end

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // work out positions for an accepted item
  always_comb begin
    restart_px = (in_row >= h);
    wr_row = restart_px ? '0 : in_row;
    wr_col = restart_px ? '0 : in_col;
    if ((WW + 1)'(wr_col) + (WW + 1)'(1) >= (WW + 1)'(w)) begin
      in_col_adv = '0;
      in_row_adv = wr_row + HW'(1);
    end else begin
      in_col_adv = wr_col + CW'(1);
      in_row_adv = wr_row;
    end
    diff_p  = (restart_px ? '0 : diff) + DW'(1);
    emit_px = (diff_p > lag);
    emit_dr = (in_row >= h) && (out_row < h);
    src_row = (op == hcr_pkg::OP_PIXEL && restart_px) ? '0 : out_row;
    src_col = (op == hcr_pkg::OP_PIXEL && restart_px) ? '0 : out_col;
    if ((WW + 1)'(src_col) + (WW + 1)'(1) >= (WW + 1)'(w)) begin
      out_col_adv = '0;
      out_row_adv = src_row + HW'(1);
    end else begin
      out_col_adv = src_col + CW'(1);
      out_row_adv = src_row;
    end
    dr_restart = (out_row_adv >= h);
    wr_addr = {3'(wr_row), wr_col};
  end

  // reflect-101 tap address
  always_comb begin
    if (gi[1]) gr = (cap_y == '0) ? HW'(1) : cap_y - HW'(1);
    else gr = cap_y;
    if (gi[0]) gc = (cap_x == '0) ? CW'(1) : cap_x - CW'(1);
    else gc = cap_x;
    unique case (hcr_pkg::TAP_ROW[ti])
      hcr_pkg::OFF_MINUS: pr = (gr == '0) ? HW'(1) : gr - HW'(1);
      hcr_pkg::OFF_PLUS:  pr = (gr == h_m1) ? h_m2 : gr + HW'(1);
      default:            pr = gr;
    endcase
    unique case (hcr_pkg::TAP_COL[ti])
      hcr_pkg::OFF_MINUS: pc = (gc == '0) ? CW'(1) : gc - CW'(1);
      hcr_pkg::OFF_PLUS:  pc = (gc == w_m1) ? w_m2 : gc + CW'(1);
      default:            pc = gc;
    endcase
    rd_addr = {3'(pr), pc};
  end

  // weight the returned tap
  always_comb begin
    term_x = $signed({4'b0000, rd_data}) * 12'(hcr_pkg::GX_COEF[rd_t]);
    term_y = $signed({4'b0000, rd_data}) * 12'(hcr_pkg::GY_COEF[rd_t]);
    tr_u   = 24'(sxx + syy);
    res    = 49'(det) - $signed({1'b0, kprod[63:16]});
  end

  // line memory: write pixels, read taps
  always_ff @(posedge clk) begin
    if (in_acc && op == hcr_pkg::OP_PIXEL) begin
      line_mem[wr_addr] <= pixel;
    end
    rd_data <= line_mem[rd_addr];
  end

  // gradient and window sums
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      grad_rdy <= 1'b0;
      grad_fin <= 1'b0;
      sum_done <= 1'b0;
    end else begin
      rd_v     <= (state == ST_READ);
      rd_t     <= ti;
      rd_gl    <= (ti == 4'd8);
      rd_fin   <= (ti == 4'd8) && (gi == 2'd3);
      grad_rdy <= rd_v && rd_gl;
      grad_fin <= rd_v && rd_fin;
      sum_done <= grad_rdy && grad_fin;
      if (rd_v) begin
        gx <= ((rd_t == 4'd0) ? 12'sd0 : gx) + term_x;
        gy <= ((rd_t == 4'd0) ? 12'sd0 : gy) + term_y;
      end
      if (in_acc) begin
        sxx <= '0;
        sxy <= '0;
        syy <= '0;
      end else if (grad_rdy) begin
        sxx <= sxx + gx * gx;
        sxy <= sxy + gx * gy;
        syy <= syy + gy * gy;
      end
    end
  end

  // control, positions, configuration and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
      diff         <= '0;
      gi           <= '0;
      ti           <= '0;
      frame_width  <= hcr_pkg::WIDTH_RESET;
      frame_height <= hcr_pkg::HEIGHT_RESET;
      harris_k     <= hcr_pkg::K_RESET;
    end else begin
      // load a finished result, or drop the one taken
      if (state == ST_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            gi       <= '0;
            ti       <= '0;
            cap_y    <= src_row;
            cap_x    <= src_col;
            cap_last <= (src_row == h_m1) && (WW'(src_col) == w - WW'(1));
            if (op == hcr_pkg::OP_PIXEL) begin
              in_row <= in_row_adv;
              in_col <= in_col_adv;
              if (emit_px) begin
                out_row <= out_row_adv;
                out_col <= out_col_adv;
                diff    <= diff_p - DW'(1);
                state   <= ST_READ;
              end else begin
                out_row <= src_row;
                out_col <= src_col;
                diff    <= diff_p;
              end
            end else if (emit_dr) begin
              state <= ST_READ;
              if (dr_restart) begin
                in_row  <= '0;
                in_col  <= '0;
                out_row <= '0;
                out_col <= '0;
                diff    <= '0;
              end else begin
                out_row <= out_row_adv;
                out_col <= out_col_adv;
                diff    <= diff - DW'(1);
              end
            end
          end
        end
        ST_READ: begin
          // step through taps, then gradients
          if (ti == 4'd8) begin
            ti <= '0;
            if (gi == 2'd3) state <= ST_ACC;
            else gi <= gi + 2'd1;
          end else begin
            ti <= ti + 4'd1;
          end
        end
        ST_ACC: begin
          if (sum_done) state <= ST_MUL1;
        end
        ST_MUL1: begin
          m_a   <= sxx * syy;
          m_b   <= sxy * sxy;
          tr2   <= tr_u * tr_u;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          det   <= m_a - m_b;
          kprod <= tr2 * harris_k;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            response      <= res[46:0];
            col           <= 10'(cap_x);
            row           <= 10'(cap_y);
            last_of_frame <= cap_last;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hcr_pkg::REG_WIDTH: begin
            frame_width <= cfg_data[10:0];
            in_row  <= '0;
            in_col  <= '0;
            out_row <= '0;
            out_col <= '0;
            diff    <= '0;
          end
          hcr_pkg::REG_HEIGHT: begin
            frame_height <= cfg_data[10:0];
            in_row  <= '0;
            in_col  <= '0;
            out_row <= '0;
            out_col <= '0;
            diff    <= '0;
          end
          hcr_pkg::REG_K: harris_k <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  `HCR_ASSERT_NOW(a_lag_bound, clk, rst, state == ST_IDLE, diff <= lag)
  `HCR_ASSERT_NOW(a_sums_in_acc, clk, rst, sum_done, state == ST_ACC)
  `HCR_ASSERT_NEXT(a_done_loads, clk, rst, state == ST_DONE && !out_stall, out_valid)
  `HCR_ASSERT_NOW(a_out_behind_in, clk, rst, state == ST_IDLE, out_row <= in_row)

endmodule

// ===== sim/harris_corner_response_tb.sv =====
module harris_corner_response_tb;

  typedef struct {
    logic signed [46:0] response;
    logic [9:0]         col;
    logic [9:0]         row;
    logic               last_of_frame;
  } corner_t;

  localparam int LINE_ROWS = 8;
  localparam int LINE_LEN  = 1024;
  // index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = hcr_pkg::OP_PIXEL;
  logic [7:0]         pixel = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [46:0] response;
  logic [9:0]         col;
  logic [9:0]         row;
  logic               last_of_frame;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = hcr_pkg::REG_WIDTH;
  logic [15:0]        cfg_data = 16'd0;

  harris_corner_response u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall), .response(response),
    .col(col), .row(row), .last_of_frame(last_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block: line store, positions and registers
  logic [7:0]  line_store [LINE_ROWS*LINE_LEN];
  int unsigned in_row, in_col, out_row, out_col;
  logic [10:0] width_reg, height_reg;
  logic [15:0] k_reg;
  corner_t     pending_corners [$];
  corner_t     got;
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned used_size(logic [10:0] v);
    if (v < 3) return 3;
    if (v > 1024) return 1024;
    return v;
  endfunction

  function automatic int mirror(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2*n - 2 - i;
    return i;
  endfunction

  function automatic int tap(int r, int c, int w, int h);
    return line_store[(mirror(r, h) % LINE_ROWS)*LINE_LEN + mirror(c, w)];
  endfunction

  function automatic void sobel(int y, int x, int w, int h, output int gx, output int gy);
    int wt [3];
    int d;
    wt = '{1, 2, 1};
    gx = 0;
    gy = 0;
    for (d = -1; d <= 1; d++) begin
      gx += wt[d+1] * (tap(y+d, x+1, w, h) - tap(y+d, x-1, w, h));
      gy += wt[d+1] * (tap(y+1, x+d, w, h) - tap(y-1, x+d, w, h));
    end
  endfunction

  function automatic void move_on(ref int unsigned r, ref int unsigned c, input int unsigned w);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
  endfunction

  // compute the corner response at the output position, then advance it
  function automatic void release_corner(int w, int h);
    int ys [2];
    int xs [2];
    int gx, gy, i, j;
    longint sxx, sxy, syy, det;
    longint unsigned tr, kterm;
    corner_t c;
    ys = '{int'(out_row), mirror(int'(out_row) - 1, h)};
    xs = '{int'(out_col), mirror(int'(out_col) - 1, w)};
    sxx = 0; sxy = 0; syy = 0;
    for (i = 0; i < 2; i++)
      for (j = 0; j < 2; j++) begin
        sobel(ys[i], xs[j], w, h, gx, gy);
        sxx += longint'(gx) * gx;
        sxy += longint'(gx) * gy;
        syy += longint'(gy) * gy;
      end
    det = sxx*syy - sxy*sxy;
    tr = sxx + syy;
    kterm = (tr * tr * longint'(k_reg)) >> 16;
    c.response = 47'(det - longint'(kterm));
    c.col = 10'(out_col);
    c.row = 10'(out_row);
    c.last_of_frame = (out_row == h-1) && (out_col == w-1);
    pending_corners = {pending_corners, c};
    move_on(out_row, out_col, w);
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  function automatic void shadow_item(logic kind, logic [7:0] px);
    int unsigned w, h, nin, nout;
    w = used_size(width_reg);
    h = used_size(height_reg);
    if (kind == hcr_pkg::OP_PIXEL) begin
      if (in_row >= h) restart_frame();
      line_store[(in_row % LINE_ROWS)*LINE_LEN + in_col] = px;
      move_on(in_row, in_col, w);
      nin = in_row*w + in_col;
      nout = out_row*w + out_col;
      if (nin - nout > 2*w + 2) release_corner(w, h);
    end else if (in_row >= h && out_row < h) begin
      release_corner(w, h);
      if (out_row >= h) restart_frame();
    end
  endfunction

  function automatic bit tail_pending();
    return in_row >= used_size(height_reg) && out_row < used_size(height_reg);
  endfunction

  // check each delivered response against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_corners.size() == 0) begin
        $error("unexpected response %0d at row %0d col %0d", response, row, col);
        error_count++;
      end else begin
        got = pending_corners.pop_front();
        if (response !== got.response) begin
          $error("response: expected %0d, got %0d", got.response, response);
          error_count++;
        end
        if (col !== got.col) begin
          $error("col: expected %0d, got %0d", got.col, col);
          error_count++;
        end
        if (row !== got.row) begin
          $error("row: expected %0d, got %0d", got.row, row);
          error_count++;
        end
        if (last_of_frame !== got.last_of_frame) begin
          $error("last_of_frame: expected %0d, got %0d", got.last_of_frame, last_of_frame);
          error_count++;
        end
      end
    end
  end

  // drive the output stall: a long hold when asked, otherwise random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic kind, logic [7:0] px);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    pixel <= px;
    do @(posedge clk); while (in_stall);
    shadow_item(kind, px);
  endtask

  task automatic settle();
    int guard;
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_corners.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcr_pkg::REG_WIDTH: begin
        width_reg = value[10:0];
        restart_frame();
      end
      hcr_pkg::REG_HEIGHT: begin
        height_reg = value[10:0];
        restart_frame();
      end
      hcr_pkg::REG_K: k_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] k);
    settle();
    write_reg(hcr_pkg::REG_WIDTH, w);
    write_reg(hcr_pkg::REG_HEIGHT, h);
    write_reg(hcr_pkg::REG_K, k);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // feed pixels until the input frame is complete, then flush the tail if asked
  task automatic run_frame(bit flush);
    do send_item(hcr_pkg::OP_PIXEL, pick_pixel());
    while (in_row < used_size(height_reg));
    if (flush)
      while (tail_pending()) send_item(hcr_pkg::OP_DRAIN, 8'($urandom));
  endtask

  // corners of extreme values, drains in and after the frame, a dropped tail
  task automatic test_directed();
    int i;
    set_frame(16'hF803, 16'd3, 16'd0);
    write_reg(REG_SPARE, 16'hFFFF);
    for (i = 0; i < 9; i++) begin
      send_item(hcr_pkg::OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
      if (i == 4) send_item(hcr_pkg::OP_DRAIN, 8'hFF);
    end
    while (tail_pending()) send_item(hcr_pkg::OP_DRAIN, 8'h00);
    send_item(hcr_pkg::OP_DRAIN, 8'h5A);
    set_frame(16'd0, 16'd2, 16'hFFFF);
    for (i = 0; i < 9; i++) send_item(hcr_pkg::OP_PIXEL, (i == 4) ? 8'd255 : 8'd0);
    // drop the tail: the next pixel opens a new frame
    run_frame(1'b0);
    run_frame(1'b1);
  endtask

  task automatic test_random(int items, int idle_in, int idle_out);
    int start;
    int i, n;
    sender_idle_pct = idle_in;
    stall_pct = idle_out;
    start = 0;
    while (start < items) begin
      if ($urandom_range(1)) begin
        set_frame(($urandom_range(9) == 0) ? 16'($urandom_range(2)) : 16'($urandom_range(3, 8)),
                  ($urandom_range(9) == 0) ?
                    (16'($urandom_range(31) << 11) | 16'($urandom_range(2))) :
                    16'($urandom_range(3, 6)),
                  16'($urandom));
      end
      n = used_size(width_reg) * used_size(height_reg);
      case ($urandom_range(9))
        0: begin
          // abandon a partial frame with stray drains
          for (i = 0; i < n/2; i++)
            send_item(($urandom_range(3) == 0) ? hcr_pkg::OP_DRAIN : hcr_pkg::OP_PIXEL,
                      pick_pixel());
          set_frame(16'($urandom_range(3, 8)), 16'($urandom_range(3, 6)), 16'($urandom));
        end
        1: run_frame(1'b0);
        default: run_frame(1'b1);
      endcase
      start += n;
    end
    settle();
  endtask

  // stall the output for a long stretch while pixels keep coming
  task automatic test_backpressure();
    int i;
    sender_idle_pct = 0;
    stall_pct = 0;
    set_frame(16'd3, 16'd30, 16'd4719);
    hold_cycles = 600;
    for (i = 0; i < 90; i++) send_item(hcr_pkg::OP_PIXEL, pick_pixel());
    while (tail_pending()) send_item(hcr_pkg::OP_DRAIN, 8'd0);
    settle();
  endtask

  // oversized registers clamp to the largest frame; partial frames only
  task automatic test_largest();
    int i;
    sender_idle_pct = 0;
    stall_pct = 0;
    set_frame(16'd2047, 16'd3, 16'd65535);
    for (i = 0; i < 150; i++) send_item(hcr_pkg::OP_PIXEL, pick_pixel());
    send_item(hcr_pkg::OP_DRAIN, 8'd0);
    set_frame(16'd3, 16'hFFFF, 16'd1);
    for (i = 0; i < 60; i++) send_item(hcr_pkg::OP_PIXEL, pick_pixel());
    settle();
  endtask

  initial begin
    foreach (line_store[i]) line_store[i] = 8'd0;
    width_reg = hcr_pkg::WIDTH_RESET;
    height_reg = hcr_pkg::HEIGHT_RESET;
    k_reg = hcr_pkg::K_RESET;
    restart_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(130, 32, 70);
    test_random(130, 70, 32);
    test_random(130, 0, 0);
    test_backpressure();
    test_largest();
    if (error_count == 0 && pending_corners.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== harris_corner_response.f =====
+incdir+src
src/hcr_pkg.sv
src/harris_corner_response.sv
sim/harris_corner_response_tb.sv
